[hdl/bfba_pkg.sv]
// ----------------------------------------------------------------------------
// bfba_pkg: shared types and constants of the best-fit block allocator
// Result codes, port field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bfba_pkg;

  // widths of the item and register fields
  localparam int unsigned FIELD_W  = 17;
  localparam int unsigned STATUS_W = 2;

  // min_growth after reset
  localparam logic [FIELD_W-1:0] GROWTH_RESET = 17'd4096;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NULL      = 2'd1,
    ST_NOSPACE   = 2'd2,
    ST_UNMATCHED = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;        // capture item, clear walk state
    logic set_null;     // null or zero request result
    logic walk_en;      // step the table walk
    logic free_fin;     // finish a free
    logic grow_init;    // load growth size
    logic grow_step;    // double growth size
    logic set_oos;      // out of space result
    logic grow_commit;  // append a block at the heap end
    logic take;         // latch result address and split decision
    logic sh_rd;        // read one entry to move
    logic sh_wr;        // write the moved entry one slot up
    logic wr_a;         // write chosen block size
    logic wr_b;         // write remainder block size
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_null;
    logic is_free;
    logic walk_done;
    logic found;
    logic grow_more;
    logic grow_fail;
    logic split;
    logic split_r;
    logic shift_any;
    logic shift_more;
  } dp_stat_t;

endpackage

[hdl/best_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// best_fit_block_allocator: best-fit heap allocator over an arena
// Top level: joins the sequencer and the table datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with action, request_size and address while busy is low;
//   the item is taken at that edge and busy stays high until it finishes.
//   The result (address_res, status) is shown for exactly one cycle with
//   done high; there is no back-pressure on the result side.
//   cfg_we with cfg_wdata writes min_growth; write only while busy is low.
// Sequence:
//   Null requests raise done in the cycle after the accepting edge. Others walk
//   the block table, one entry per cycle from the table RAM read port; a free
//   then finishes, a fit is taken, or the heap grows by min_growth, doubled
//   until it covers the request (out of space if it cannot). A split that
//   moves higher entries up reads, then writes each moved entry on the single
//   RAM port pair, then writes the chosen and the remainder block sizes.
// Reset:
//   rst empties the arena (no blocks, heap end zero) and sets min_growth
//   to 4096; no clearing pass is needed.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
  parameter longint unsigned ARENA_BYTES  = 65536,
  parameter int unsigned     MAX_BLOCKS   = 64,
  parameter int unsigned     HEADER_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           cfg_we,
  input  logic [bfba_pkg::FIELD_W-1:0]   cfg_wdata,
  input  logic                           action,
  input  logic [bfba_pkg::FIELD_W-1:0]   request_size,
  input  logic [bfba_pkg::FIELD_W-1:0]   address,
  output logic [bfba_pkg::FIELD_W-1:0]   address_res,
  output logic [bfba_pkg::STATUS_W-1:0]  status
);

  bfba_pkg::ctrl_cmd_t cmd;
  bfba_pkg::dp_stat_t  stat;

  bfba_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  bfba_dp #(
    .ARENA_BYTES (ARENA_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .action      (action),
    .request_size(request_size),
    .address     (address),
    .address_res (address_res),
    .status      (status)
  );

endmodule

[hdl/bfba_ram.sv]
// ----------------------------------------------------------------------------
// bfba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfba_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/bfba_ctrl.sv]
// ----------------------------------------------------------------------------
// bfba_ctrl: allocator sequencer
// Steps an item through walk, growth, split and table update.
// ----------------------------------------------------------------------------
module bfba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  bfba_pkg::dp_stat_t   stat,
  output bfba_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_WALK   = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_GROW   = 10'b0000001000,
    S_TAKE   = 10'b0000010000,
    S_SHRD   = 10'b0000100000,
    S_SHWR   = 10'b0001000000,
    S_WRA    = 10'b0010000000,
    S_WRB    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (stat.in_null) begin
            cmd.set_null = 1'b1;
            state_next   = S_DONE;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.walk_en = 1'b1;
        if (stat.walk_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_free) begin
          cmd.free_fin = 1'b1;
          state_next   = S_DONE;
        end else if (stat.found) begin
          state_next = S_TAKE;
        end else begin
          cmd.grow_init = 1'b1;
          state_next    = S_GROW;
        end
      end
      S_GROW: begin
        if (stat.grow_more) begin
          cmd.grow_step = 1'b1;
        end else if (stat.grow_fail) begin
          cmd.set_oos = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.grow_commit = 1'b1;
          state_next      = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.take = 1'b1;
        if (stat.split && stat.shift_any) begin
          state_next = S_SHRD;
        end else begin
          state_next = S_WRA;
        end
      end
      S_SHRD: begin
        cmd.sh_rd  = 1'b1;
        state_next = S_SHWR;
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        if (stat.shift_more) begin
          state_next = S_SHRD;
        end else begin
          state_next = S_WRA;
        end
      end
      S_WRA: begin
        cmd.wr_a = 1'b1;
        if (stat.split_r) begin
          state_next = S_WRB;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WRB: begin
        cmd.wr_b   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

[hdl/bfba_dp.sv]
// ----------------------------------------------------------------------------
// bfba_dp: allocator datapath
// Block table RAM (used flag and size), walk accumulators, growth and results.
// ----------------------------------------------------------------------------
module bfba_dp #(
  parameter longint unsigned ARENA_BYTES  = 65536,
  parameter int unsigned     MAX_BLOCKS   = 64,
  parameter int unsigned     HEADER_BYTES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bfba_pkg::ctrl_cmd_t               cmd,
  output bfba_pkg::dp_stat_t                stat,
  input  logic                              cfg_we,
  input  logic [bfba_pkg::FIELD_W-1:0]      cfg_wdata,
  input  logic                              action,
  input  logic [bfba_pkg::FIELD_W-1:0]      request_size,
  input  logic [bfba_pkg::FIELD_W-1:0]      address,
  output logic [bfba_pkg::FIELD_W-1:0]      address_res,
  output logic [bfba_pkg::STATUS_W-1:0]     status
);

  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SW  = $clog2(ARENA_BYTES + 1);
  localparam int unsigned PW  = (SW + 2 > bfba_pkg::FIELD_W + 1) ? SW + 2
                                                                 : bfba_pkg::FIELD_W + 1;
  localparam logic [PW-1:0] ARENA_P = PW'(ARENA_BYTES);
  localparam logic [PW-1:0] HDR_P   = PW'(HEADER_BYTES);
  localparam logic [CW-1:0] MAX_C   = CW'(MAX_BLOCKS);

  logic [bfba_pkg::FIELD_W-1:0] min_growth;
  logic                         is_free;
  logic [PW-1:0]                req;
  logic [PW-1:0]                addr;
  logic [CW-1:0]                count;
  logic [PW-1:0]                heap_end;
  logic [CW-1:0]                rd_idx;
  logic                         proc_valid;
  logic [IW-1:0]                proc_idx;
  logic [PW-1:0]                start_off;
  logic                         found;
  logic [IW-1:0]                best;
  logic [PW-1:0]                best_size;
  logic [PW-1:0]                best_start;
  logic                         hit;
  logic [IW-1:0]                hit_idx;
  logic [SW-1:0]                hit_size;
  logic [PW-1:0]                grow;
  logic                         split_r;
  logic [IW-1:0]                sh_ptr;
  logic [bfba_pkg::FIELD_W-1:0] res_addr;
  bfba_pkg::status_t            res_status;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [SW:0]   ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [SW:0]   ram_rdata;
  logic [PW-1:0] cur_size;
  logic          cur_used;
  logic          issue;
  logic          split_c;
  logic [PW-1:0] rem;

  // each entry holds {used, size}
  bfba_ram #(.WIDTH(SW + 1), .DEPTH(MAX_BLOCKS)) u_size_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cur_size = PW'(ram_rdata[SW-1:0]);
  assign cur_used = ram_rdata[SW];
  assign issue    = cmd.walk_en && (rd_idx < count);
  assign split_c  = (best_size > req) && ((best_size - req) > HDR_P) && (count < MAX_C);
  assign rem      = best_size - req - HDR_P;

  // table RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sh_ptr + IW'(1);
    ram_wdata = ram_rdata;
    ram_raddr = cmd.walk_en ? rd_idx[IW-1:0] : sh_ptr;
    if (cmd.sh_wr) begin
      ram_we = 1'b1;
    end else if (cmd.wr_a) begin
      ram_we    = 1'b1;
      ram_waddr = best;
      ram_wdata = {1'b1, split_r ? req[SW-1:0] : best_size[SW-1:0]};
    end else if (cmd.wr_b) begin
      ram_we    = 1'b1;
      ram_waddr = best + IW'(1);
      ram_wdata = {1'b0, rem[SW-1:0]};
    end else if (cmd.free_fin && hit) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx;
      ram_wdata = {1'b0, hit_size};
    end
  end

  // status to the sequencer
  always_comb begin
    stat            = '0;
    stat.in_null    = action ? (address == '0) : (request_size == '0);
    stat.is_free    = is_free;
    stat.walk_done  = !(rd_idx < count) && !proc_valid;
    stat.found      = found;
    stat.grow_more  = (grow < req) && (grow <= ARENA_P);
    stat.grow_fail  = (count >= MAX_C) || (grow > ARENA_P) ||
                      ((heap_end + HDR_P + grow) > ARENA_P);
    stat.split      = split_c;
    stat.split_r    = split_r;
    stat.shift_any  = ({1'b0, count} > ({1'b0, CW'(best)} + (CW + 1)'(1)));
    stat.shift_more = ({1'b0, sh_ptr} > ({1'b0, best} + (IW + 1)'(1)));
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_growth <= bfba_pkg::GROWTH_RESET;
    end else if (cfg_we) begin
      min_growth <= cfg_wdata;
    end
  end

  // item capture, walk, growth and results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      is_free    <= action;
      req        <= PW'(request_size);
      addr       <= PW'(address);
      rd_idx     <= '0;
      proc_valid <= 1'b0;
      start_off  <= '0;
      found      <= 1'b0;
      hit        <= 1'b0;
    end
    if (cmd.set_null) begin
      res_addr   <= '0;
      res_status <= bfba_pkg::ST_NULL;
    end
    // walk: address issued, entry evaluated in the cycle after
    if (cmd.walk_en) begin
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      proc_valid <= issue;
      proc_idx   <= rd_idx[IW-1:0];
      if (proc_valid) begin
        if (!cur_used && cur_size >= req && (!found || cur_size < best_size)) begin
          found      <= 1'b1;
          best       <= proc_idx;
          best_size  <= cur_size;
          best_start <= start_off;
        end
        if (start_off + HDR_P == addr) begin
          hit      <= 1'b1;
          hit_idx  <= proc_idx;
          hit_size <= ram_rdata[SW-1:0];
        end
        start_off <= start_off + HDR_P + cur_size;
      end
    end
    if (cmd.free_fin) begin
      res_addr   <= '0;
      res_status <= hit ? bfba_pkg::ST_OK : bfba_pkg::ST_UNMATCHED;
    end
    // growth size: min_growth (zero counts as one), doubled until it fits
    if (cmd.grow_init) begin
      grow <= (min_growth == '0) ? PW'(1) : PW'(min_growth);
    end else if (cmd.grow_step) begin
      grow <= grow << 1;
    end
    if (cmd.set_oos) begin
      res_addr   <= '0;
      res_status <= bfba_pkg::ST_NOSPACE;
    end
    if (cmd.grow_commit) begin
      best       <= count[IW-1:0];
      best_size  <= grow;
      best_start <= heap_end;
    end
    if (cmd.take) begin
      split_r    <= split_c;
      sh_ptr     <= IW'(count - CW'(1));
      res_addr   <= bfba_pkg::FIELD_W'(best_start + HDR_P);
      res_status <= bfba_pkg::ST_OK;
    end
    if (cmd.sh_wr) begin
      sh_ptr <= sh_ptr - IW'(1);
    end
  end

  // table control state: block count, heap end
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      heap_end <= '0;
    end else begin
      if (cmd.grow_commit) begin
        count    <= count + CW'(1);
        heap_end <= heap_end + HDR_P + grow;
      end
      // a split adds the remainder entry
      if (cmd.take && split_c) begin
        count <= count + CW'(1);
      end
    end
  end

  assign address_res = res_addr;
  assign status      = res_status;

  // table never exceeds its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= MAX_C)
    else $error("block count beyond table size");
  // heap never grows past the arena
  a_heap_max: assert property (@(posedge clk) disable iff (rst) heap_end <= ARENA_P)
    else $error("heap end beyond arena");
  // a commit only happens when growth was checked to fit
  a_commit_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.grow_commit |-> (count < MAX_C) && ((heap_end + HDR_P + grow) <= ARENA_P))
    else $error("growth committed without room");
  // a split always leaves room for the remainder entry
  a_split_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && split_c) |=> (count <= MAX_C) && split_r)
    else $error("split without table room");

endmodule
